[design/sparse_coordinate_store_unit_macros.svh]
// assertion macros used by the checker file
`ifndef SPARSE_COORDINATE_STORE_UNIT_MACROS_SVH
`define SPARSE_COORDINATE_STORE_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sparse coordinate store check failed");

// next-cycle implication, disabled while reset is low
`define SCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sparse coordinate store check failed");

`endif

[design/scs_pkg.sv]
// types, constants and helpers for the sparse coordinate store
package scs_pkg;

  localparam int CAPACITY    = 64;
  localparam int MAX_MODES   = 4;
  localparam int INDEX_BITS  = 16;
  localparam int LANE_STRIDE = 16;
  localparam int COORD_W     = 64;
  localparam int VALUE_W     = 64;
  localparam int MODE_W      = 3;
  localparam int ENTRY_W     = 7;
  localparam int POS_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int GROUP_SIZE  = 8;
  localparam int GROUP_COUNT = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_UPDATE,
    ACT_REMOVE,
    ACT_APPEND
  } action_t;

  typedef struct packed {
    logic               match_en;
    logic               select_en;
    logic               apply_en;
    action_t            action;
    logic [COORD_W-1:0] coord;
    logic [VALUE_W-1:0] value;
    logic [COORD_W-1:0] key_mask;
    logic [CNT_W-1:0]   count;
  } ctrl_t;

  // mask of the index bits of the active modes, mode count clamped to 1..MAX_MODES
  function automatic logic [COORD_W-1:0] lane_mask(input logic [MODE_W-1:0] modes);
    logic [COORD_W-1:0] m;
    logic [MODE_W-1:0]  active;
    active = modes;
    if (active == '0) active = MODE_W'(1);
    if (active > MODE_W'(MAX_MODES)) active = MODE_W'(MAX_MODES);
    m = '0;
    for (int k = 0; k < MAX_MODES; k++) begin
      if (k < int'(active)) m[k*LANE_STRIDE +: INDEX_BITS] = '1;
    end
    return m;
  endfunction

  localparam logic [COORD_W-1:0] FULL_MASK = lane_mask(MODE_W'(MAX_MODES));

endpackage

[design/scs_if.sv]
// channel interfaces for request and response transactions
interface scs_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [scs_pkg::COORD_W-1:0]  coordinate;
  logic signed [scs_pkg::VALUE_W-1:0] write_value;

  modport source (output valid, command, coordinate, write_value, input ready);
  modport sink   (input valid, command, coordinate, write_value, output ready);
endinterface

interface scs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [scs_pkg::VALUE_W-1:0] read_value;
  logic                               found;
  logic                               dropped;
  logic [scs_pkg::ENTRY_W-1:0]        entry_count;

  modport source (output valid, read_value, found, dropped, entry_count, input ready);
  modport sink   (input valid, read_value, found, dropped, entry_count, output ready);
endinterface

[design/sparse_coordinate_store_unit.sv]
// sparse coordinate store: up to 64 nonzero (coordinate, value) entries kept in
// insertion order in a chain of cells. Each request transaction passes through
// these steps from acceptance to a result in the output register: a match step in
// which every cell compares its key, a select step in which the first match is
// picked by a wide subtract across the chain, an apply step in which the cells
// apply the write (update in place, append at the tail, or shift down one place
// from their neighbor on a remove) while the read data is gathered in groups of
// eight, and a final step that merges the groups into the result. One request is
// in flight at a time; the next is taken in the cycle after the result is loaded
// into the output register, even if that result is not yet taken. A result still
// waiting in the output register holds the next request in its final step until
// the result is taken. mode_count (register 0) selects how many 16-bit modes are
// compared.
module sparse_coordinate_store_unit (
  input  logic        clk,
  input  logic        rst_n,
  scs_in_if.sink      in_chan,
  scs_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_MODE_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SELECT,
    ST_APPLY,
    ST_DONE
  } state_t;

  localparam int PAD_W = scs_pkg::GROUP_COUNT * scs_pkg::GROUP_SIZE;

  state_t                               state_r;
  logic [scs_pkg::MODE_W-1:0]           mode_count_r;
  logic                                 cmd_r;
  logic [scs_pkg::COORD_W-1:0]          coord_r;
  logic [scs_pkg::VALUE_W-1:0]          val_r;
  logic [scs_pkg::CNT_W-1:0]            count_r;
  logic                                 hit_any_r;
  logic                                 dropped_r;
  logic [scs_pkg::VALUE_W-1:0]          group_r [scs_pkg::GROUP_COUNT];
  logic                                 out_valid_r;
  logic [scs_pkg::VALUE_W-1:0]          out_value_r;
  logic                                 out_found_r;
  logic                                 out_dropped_r;
  logic [scs_pkg::ENTRY_W-1:0]          out_count_r;

  scs_pkg::ctrl_t                       ctrl;
  scs_pkg::action_t                     action;
  logic [scs_pkg::CAPACITY-1:0]         hit_vec;
  logic [scs_pkg::CAPACITY-1:0]         first_vec;
  logic [scs_pkg::CAPACITY-1:0]         ge_vec;
  logic [scs_pkg::COORD_W-1:0]          key_w   [scs_pkg::CAPACITY];
  logic [scs_pkg::VALUE_W-1:0]          value_w [scs_pkg::CAPACITY];
  logic [scs_pkg::VALUE_W-1:0]          rd_pad  [PAD_W];
  logic [scs_pkg::VALUE_W-1:0]          group_nxt [scs_pkg::GROUP_COUNT];
  logic [scs_pkg::VALUE_W-1:0]          merged;
  logic                                 cfg_write;
  logic                                 is_full;
  logic                                 val_zero;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_MODE_COUNT) ? 32'(mode_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_count_r <= scs_pkg::MODE_W'(1);
    end else if (cfg_write && paddr[2] == REG_MODE_COUNT) begin
      mode_count_r <= pwdata[scs_pkg::MODE_W-1:0];
    end
  end

  // first match and the cells at or above it
  assign first_vec = hit_vec & (~hit_vec + scs_pkg::CAPACITY'(1));
  assign ge_vec    = ~(first_vec - scs_pkg::CAPACITY'(1));

  assign is_full  = count_r == scs_pkg::CNT_W'(scs_pkg::CAPACITY);
  assign val_zero = val_r == '0;

  always_comb begin
    action = scs_pkg::ACT_NONE;
    if (cmd_r == scs_pkg::CMD_WRITE) begin
      if (hit_any_r) begin
        action = val_zero ? scs_pkg::ACT_REMOVE : scs_pkg::ACT_UPDATE;
      end else if (!val_zero && !is_full) begin
        action = scs_pkg::ACT_APPEND;
      end
    end
  end

  always_comb begin
    ctrl.match_en  = state_r == ST_MATCH;
    ctrl.select_en = state_r == ST_SELECT;
    ctrl.apply_en  = state_r == ST_APPLY;
    ctrl.action    = action;
    ctrl.coord     = coord_r;
    ctrl.value     = val_r;
    ctrl.key_mask  = scs_pkg::lane_mask(mode_count_r);
    ctrl.count     = count_r;
  end

  // cell chain
  for (genvar i = 0; i < scs_pkg::CAPACITY; i++) begin : g_cell
    logic [scs_pkg::COORD_W-1:0] nk;
    logic [scs_pkg::VALUE_W-1:0] nv;
    if (i + 1 < scs_pkg::CAPACITY) begin : g_link
      assign nk = key_w[i+1];
      assign nv = value_w[i+1];
    end else begin : g_end
      assign nk = '0;
      assign nv = '0;
    end
    scs_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .pos_i        (scs_pkg::POS_W'(i)),
      .ctrl_i       (ctrl),
      .sel_i        (first_vec[i]),
      .ge_i         (ge_vec[i]),
      .next_key_i   (nk),
      .next_value_i (nv),
      .key_o        (key_w[i]),
      .value_o      (value_w[i]),
      .hit_o        (hit_vec[i]),
      .rd_value_o   (rd_pad[i])
    );
  end

  for (genvar i = scs_pkg::CAPACITY; i < PAD_W; i++) begin : g_pad
    assign rd_pad[i] = '0;
  end

  // read data gathered in groups, then merged
  always_comb begin
    for (int g = 0; g < scs_pkg::GROUP_COUNT; g++) begin
      group_nxt[g] = '0;
      for (int j = 0; j < scs_pkg::GROUP_SIZE; j++) begin
        group_nxt[g] = group_nxt[g] | rd_pad[g*scs_pkg::GROUP_SIZE + j];
      end
    end
  end

  always_comb begin
    merged = '0;
    for (int g = 0; g < scs_pkg::GROUP_COUNT; g++) begin
      merged = merged | group_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_APPLY) begin
      for (int g = 0; g < scs_pkg::GROUP_COUNT; g++) begin
        group_r[g] <= group_nxt[g];
      end
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      hit_any_r   <= 1'b0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && state_r != ST_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_chan.valid) begin
            cmd_r   <= in_chan.command;
            coord_r <= in_chan.coordinate;
            val_r   <= in_chan.write_value;
            state_r <= ST_MATCH;
          end
        end
        ST_MATCH: begin
          state_r <= ST_SELECT;
        end
        ST_SELECT: begin
          hit_any_r <= |hit_vec;
          state_r   <= ST_APPLY;
        end
        ST_APPLY: begin
          dropped_r <= (cmd_r == scs_pkg::CMD_WRITE) && !hit_any_r && !val_zero && is_full;
          unique case (action)
            scs_pkg::ACT_REMOVE: count_r <= count_r - scs_pkg::CNT_W'(1);
            scs_pkg::ACT_APPEND: count_r <= count_r + scs_pkg::CNT_W'(1);
            default: begin
            end
          endcase
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r   <= 1'b1;
            out_value_r   <= (cmd_r == scs_pkg::CMD_READ && hit_any_r) ? merged : '0;
            out_found_r   <= hit_any_r;
            out_dropped_r <= dropped_r;
            out_count_r   <= scs_pkg::ENTRY_W'(count_r);
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_chan.ready        = state_r == ST_IDLE;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.read_value  = out_value_r;
  assign out_chan.found       = out_found_r;
  assign out_chan.dropped     = out_dropped_r;
  assign out_chan.entry_count = out_count_r;

endmodule

[design/scs_cell.sv]
// one storage cell of the entry chain: key, value, match and shift
module scs_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [scs_pkg::POS_W-1:0]   pos_i,
  input  scs_pkg::ctrl_t              ctrl_i,
  input  logic                        sel_i,
  input  logic                        ge_i,
  input  logic [scs_pkg::COORD_W-1:0] next_key_i,
  input  logic [scs_pkg::VALUE_W-1:0] next_value_i,
  output logic [scs_pkg::COORD_W-1:0] key_o,
  output logic [scs_pkg::VALUE_W-1:0] value_o,
  output logic                        hit_o,
  output logic [scs_pkg::VALUE_W-1:0] rd_value_o
);

  logic [scs_pkg::COORD_W-1:0] key_r;
  logic [scs_pkg::VALUE_W-1:0] value_r;
  logic                        hit_r;
  logic                        sel_r;
  logic                        ge_r;
  logic                        in_range;
  logic                        at_tail;

  assign in_range = scs_pkg::CNT_W'(pos_i) < ctrl_i.count;
  assign at_tail  = scs_pkg::CNT_W'(pos_i) == ctrl_i.count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
      sel_r <= 1'b0;
      ge_r  <= 1'b0;
    end else begin
      if (ctrl_i.match_en) begin
        hit_r <= in_range && (((key_r ^ ctrl_i.coord) & ctrl_i.key_mask) == '0);
      end
      if (ctrl_i.select_en) begin
        sel_r <= sel_i;
        ge_r  <= ge_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.apply_en) begin
      unique case (ctrl_i.action)
        scs_pkg::ACT_UPDATE: begin
          if (sel_r) value_r <= ctrl_i.value;
        end
        scs_pkg::ACT_REMOVE: begin
          if (ge_r) begin
            key_r   <= next_key_i;
            value_r <= next_value_i;
          end
        end
        scs_pkg::ACT_APPEND: begin
          if (at_tail) begin
            key_r   <= ctrl_i.coord & scs_pkg::FULL_MASK;
            value_r <= ctrl_i.value;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign key_o      = key_r;
  assign value_o    = value_r;
  assign hit_o      = hit_r;
  assign rd_value_o = sel_r ? value_r : '0;

endmodule

[design/scs_checker.sv]
// port-level checks for the sparse coordinate store and their binding
`include "sparse_coordinate_store_unit_macros.svh"

module scs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [scs_pkg::VALUE_W-1:0] out_read_value,
  input logic                              out_found,
  input logic                              out_dropped,
  input logic [scs_pkg::ENTRY_W-1:0]       out_entry_count
);

  `SCS_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `SCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SCS_ASSERT_IMP(a_drop_when_full, out_valid && out_dropped, !out_found && out_entry_count == scs_pkg::ENTRY_W'(scs_pkg::CAPACITY))
  `SCS_ASSERT_IMP(a_miss_reads_zero, out_valid && !out_found, out_read_value == '0)

endmodule

bind sparse_coordinate_store_unit scs_checker u_scs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_read_value  (out_chan.read_value),
  .out_found       (out_chan.found),
  .out_dropped     (out_chan.dropped),
  .out_entry_count (out_chan.entry_count)
);
